// ===== rtl/closed_polyline_subdivider_top_assert.svh =====
// Assertion macros shared by the closed polyline subdivider RTL.
`ifndef CLOSED_POLYLINE_SUBDIVIDER_TOP_ASSERT_SVH
`define CLOSED_POLYLINE_SUBDIVIDER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on i_clk, off during reset
`define CPS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cps assertion failed");
// next-cycle implication, sampled on i_clk, off during reset
`define CPS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cps assertion failed");
`else
`define CPS_ASSERT_IMP(lbl, ante, cons)
`define CPS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/cps_pkg.sv =====
// Types and constants of the closed polyline subdivider.
package cps_pkg;

    localparam int IDXW   = 10;
    localparam int CRDW   = 16;
    localparam int PCW    = 11;
    localparam int EDGEW  = 35;
    localparam int APB_DW = 64;
    localparam int APB_AW = 4;

    localparam logic [2:0] CMD_APPEND = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_GROW   = 3'd2;
    localparam logic [2:0] CMD_READ   = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // register select is paddr bit 3 (8-byte spacing)
    localparam logic REG_EDGE = 1'b0;
    localparam logic REG_PTS  = 1'b1;

    localparam logic [EDGEW-1:0] EDGE_RST = 35'd1024;
    localparam logic [PCW-1:0]   PTS_RST  = 11'd1024;

    typedef struct packed {
        logic [EDGEW-1:0] max_edge_sq;
        logic [PCW-1:0]   max_points;
    } t_cfg;

    typedef struct packed {
        logic signed [CRDW-1:0] x;
        logic signed [CRDW-1:0] y;
    } t_point;

endpackage

// ===== rtl/cps_regs.sv =====
// APB configuration registers of the closed polyline subdivider.
module cps_regs
    import cps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic w_sel;
    logic w_wr;

    assign w_sel = paddr[APB_AW-1];
    assign w_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_edge_sq <= EDGE_RST;
            r_cfg.max_points  <= PTS_RST;
        end else if (w_wr) begin
            unique case (w_sel)
                REG_EDGE: r_cfg.max_edge_sq <= pwdata[EDGEW-1:0];
                REG_PTS:  r_cfg.max_points  <= pwdata[PCW-1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (w_sel)
            REG_EDGE: prdata = APB_DW'(r_cfg.max_edge_sq);
            REG_PTS:  prdata = APB_DW'(r_cfg.max_points);
            default:  prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/closed_polyline_subdivider_top.sv =====
// Closed polyline point store with append, insert, read, clear and grow pass.
//
// Usage: drive a command with start high; it is taken when busy is low. The
// block then runs the command through a small sequencer and one shared
// 17x17 multiplier, and shows exactly one result on o_out_x, o_out_y,
// o_point_count and o_status for one cycle, marked by o_valid. The receiver
// cannot stall; the result is gone after that cycle.
// Clear, unused codes, errors and a grow pass on an empty store answer
// straight from decode. Read waits for the memory read; append and insert
// write the point, and an insert below the end first moves each entry from
// the index up one slot, top entry first. A grow pass tests each edge of
// the closed polyline with the shared multiplier and inserts the midpoint
// of a long edge while the limits allow. One command is in flight.
// A new command may be accepted in the cycle its predecessor's o_valid is high.
// Reset (synchronous, active low) empties the store and restores the
// registers to max_edge_sq = 1024 and max_points = 1024. Registers sit on an
// APB port at byte 0 (max_edge_sq) and byte 8 (max_points); write them only
// while busy is low.
`include "closed_polyline_subdivider_top_assert.svh"
module closed_polyline_subdivider_top
    import cps_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [2:0]             i_command,
    input  logic [IDXW-1:0]        i_index,
    input  logic signed [CRDW-1:0] i_px,
    input  logic signed [CRDW-1:0] i_py,
    output logic                   o_valid,
    output logic signed [CRDW-1:0] o_out_x,
    output logic signed [CRDW-1:0] o_out_y,
    output logic [PCW-1:0]         o_point_count,
    output logic [1:0]             o_status,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_AW-1:0]      paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > PCW) ? CW : PCW;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_DEC   = 12'b0000_0000_0010,
        S_RDW   = 12'b0000_0000_0100,
        S_GLD   = 12'b0000_0000_1000,
        S_GRDJ  = 12'b0000_0001_0000,
        S_GDIF  = 12'b0000_0010_0000,
        S_GSQX  = 12'b0000_0100_0000,
        S_GSQY  = 12'b0000_1000_0000,
        S_GCMP  = 12'b0001_0000_0000,
        S_SHIFT = 12'b0010_0000_0000,
        S_SHEND = 12'b0100_0000_0000,
        S_PUT   = 12'b1000_0000_0000
    } t_state;

    t_cfg w_cfg;

    t_state                 r_state;
    logic [CW-1:0]          r_count;
    logic [2:0]             r_cmd;
    logic [IDXW-1:0]        r_idx;
    t_point                 r_newpt;
    t_point                 r_cur;
    t_point                 r_nxt;
    t_point                 r_rdata;
    logic [AW-1:0]          r_i;
    logic [AW-1:0]          r_pos;
    logic [AW-1:0]          r_src;
    logic [AW-1:0]          r_wa;
    logic                   r_pend;
    logic signed [CRDW:0]   r_dx;
    logic signed [CRDW:0]   r_dy;
    logic [31:0]            r_sqa;
    logic [31:0]            r_sqb;
    logic                   r_ov;
    logic signed [CRDW-1:0] r_ox;
    logic signed [CRDW-1:0] r_oy;
    logic [1:0]             r_ost;

    t_point mem [CAPACITY];

    logic [CW-1:0]          w_ip1;
    logic [AW-1:0]          w_j;
    logic [XW-1:0]          w_cnt_x;
    logic [XW-1:0]          w_idx_x;
    logic [XW-1:0]          w_mp_x;
    logic                   w_full;
    logic                   w_grow_ok;
    logic [32:0]            w_d2;
    logic                   w_long;
    logic signed [CRDW:0]   w_sx;
    logic signed [CRDW:0]   w_sy;
    t_point                 w_mid;
    logic signed [CRDW:0]   w_mop;
    logic signed [2*CRDW+1:0] w_prod;
    logic [AW-1:0]          w_ra;
    logic                   w_we;
    logic [AW-1:0]          w_wa;
    t_point                 w_wd;

    cps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    assign pready = 1'b1;

    // walk position helpers; the last point pairs with the first
    assign w_ip1   = CW'(r_i) + CW'(1);
    assign w_j     = (w_ip1 < r_count) ? w_ip1[AW-1:0] : '0;
    assign w_cnt_x = XW'(r_count);
    assign w_idx_x = XW'(r_idx);
    assign w_mp_x  = XW'(w_cfg.max_points);
    assign w_full  = (r_count >= CAP_C);
    assign w_grow_ok = (w_cnt_x < w_mp_x) && !w_full;

    assign w_d2   = {1'b0, r_sqa} + {1'b0, r_sqb};
    assign w_long = EDGEW'(w_d2) > w_cfg.max_edge_sq;

    // floored midpoint: arithmetic halving of the 17-bit sum
    assign w_sx      = {r_cur.x[CRDW-1], r_cur.x} + {r_nxt.x[CRDW-1], r_nxt.x};
    assign w_sy      = {r_cur.y[CRDW-1], r_cur.y} + {r_nxt.y[CRDW-1], r_nxt.y};
    assign w_mid.x   = w_sx[CRDW:1];
    assign w_mid.y   = w_sy[CRDW:1];

    // shared squaring unit
    assign w_mop  = (r_state == S_GSQX) ? r_dx : r_dy;
    assign w_prod = w_mop * w_mop;

    always_comb begin
        unique case (r_state)
            S_DEC:   w_ra = (r_cmd == CMD_GROW) ? '0 : AW'(r_idx);
            S_GRDJ:  w_ra = w_j;
            S_SHIFT: w_ra = r_src;
            default: w_ra = '0;
        endcase
    end

    assign w_we = ((r_state == S_SHIFT) && r_pend) || (r_state == S_SHEND) ||
                  (r_state == S_PUT);
    assign w_wa = (r_state == S_PUT) ? r_pos : r_wa;
    assign w_wd = (r_state == S_PUT) ? r_newpt : r_rdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        r_rdata <= mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd     <= i_command;
                        r_idx     <= i_index;
                        r_newpt.x <= i_px;
                        r_newpt.y <= i_py;
                        r_state   <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_ox <= '0;
                    r_oy <= '0;
                    unique case (r_cmd)
                        CMD_APPEND: begin
                            if (w_full) begin
                                r_ov    <= 1'b1;
                                r_ost   <= ST_FULL;
                                r_state <= S_IDLE;
                            end else begin
                                r_pos   <= r_count[AW-1:0];
                                r_state <= S_PUT;
                            end
                        end
                        CMD_INSERT: begin
                            if (w_idx_x > w_cnt_x) begin
                                r_ov    <= 1'b1;
                                r_ost   <= ST_RANGE;
                                r_state <= S_IDLE;
                            end else if (w_full) begin
                                r_ov    <= 1'b1;
                                r_ost   <= ST_FULL;
                                r_state <= S_IDLE;
                            end else begin
                                r_pos   <= AW'(r_idx);
                                r_src   <= AW'(r_count - CW'(1));
                                r_pend  <= 1'b0;
                                r_state <= (w_idx_x < w_cnt_x) ? S_SHIFT : S_PUT;
                            end
                        end
                        CMD_GROW: begin
                            if (r_count == '0) begin
                                r_ov    <= 1'b1;
                                r_ost   <= ST_OK;
                                r_state <= S_IDLE;
                            end else begin
                                r_state <= S_GLD;
                            end
                        end
                        CMD_READ: begin
                            if (w_idx_x >= w_cnt_x) begin
                                r_ov    <= 1'b1;
                                r_ost   <= ST_RANGE;
                                r_state <= S_IDLE;
                            end else begin
                                r_state <= S_RDW;
                            end
                        end
                        CMD_CLEAR: begin
                            r_count <= '0;
                            r_ov    <= 1'b1;
                            r_ost   <= ST_OK;
                            r_state <= S_IDLE;
                        end
                        default: begin
                            r_ov    <= 1'b1;
                            r_ost   <= ST_OK;
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_RDW: begin
                    r_ox    <= r_rdata.x;
                    r_oy    <= r_rdata.y;
                    r_ov    <= 1'b1;
                    r_ost   <= ST_OK;
                    r_state <= S_IDLE;
                end
                S_GLD: begin
                    r_cur   <= r_rdata;
                    r_i     <= '0;
                    r_state <= S_GRDJ;
                end
                S_GRDJ: begin
                    r_state <= S_GDIF;
                end
                S_GDIF: begin
                    r_nxt   <= r_rdata;
                    r_dx    <= {r_rdata.x[CRDW-1], r_rdata.x} - {r_cur.x[CRDW-1], r_cur.x};
                    r_dy    <= {r_rdata.y[CRDW-1], r_rdata.y} - {r_cur.y[CRDW-1], r_cur.y};
                    r_state <= S_GSQX;
                end
                S_GSQX: begin
                    r_sqa   <= w_prod[31:0];
                    r_state <= S_GSQY;
                end
                S_GSQY: begin
                    r_sqb   <= w_prod[31:0];
                    r_state <= S_GCMP;
                end
                S_GCMP: begin
                    if (w_long && w_grow_ok) begin
                        r_newpt <= w_mid;
                        r_pos   <= w_ip1[AW-1:0];
                        r_src   <= AW'(r_count - CW'(1));
                        r_pend  <= 1'b0;
                        r_state <= (w_ip1 < r_count) ? S_SHIFT : S_PUT;
                    end else if (w_ip1 == r_count) begin
                        r_ov    <= 1'b1;
                        r_ost   <= ST_OK;
                        r_state <= S_IDLE;
                    end else begin
                        r_cur   <= r_nxt;
                        r_i     <= w_ip1[AW-1:0];
                        r_state <= S_GRDJ;
                    end
                end
                S_SHIFT: begin
                    // read one entry, write the previous one a slot higher
                    r_wa   <= r_src + AW'(1);
                    r_pend <= 1'b1;
                    if (r_src == r_pos) begin
                        r_state <= S_SHEND;
                    end else begin
                        r_src <= r_src - AW'(1);
                    end
                end
                S_SHEND: begin
                    r_pend  <= 1'b0;
                    r_state <= S_PUT;
                end
                S_PUT: begin
                    r_count <= r_count + CW'(1);
                    if (r_cmd == CMD_GROW) begin
                        // continue the walk from the new midpoint
                        r_cur   <= r_newpt;
                        r_i     <= r_pos;
                        r_state <= S_GRDJ;
                    end else begin
                        r_ov    <= 1'b1;
                        r_ost   <= ST_OK;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_ov;
    assign o_out_x       = r_ox;
    assign o_out_y       = r_oy;
    assign o_status      = r_ost;
    assign o_point_count = PCW'(r_count);

    `CPS_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    `CPS_ASSERT_IMP(a_valid_idle, o_valid, !busy)
    `CPS_ASSERT_IMP(a_count_cap, 1'b1, r_count <= CAP_C)
    `CPS_ASSERT_IMP(a_wr_in_use, w_we, (CW'(w_wa) <= r_count) && (r_count < CAP_C))
    `CPS_ASSERT_IMP(a_err_zero, o_valid && (o_status != ST_OK), (o_out_x == '0) && (o_out_y == '0))

endmodule

// ===== tb/tb_closed_polyline_subdivider_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench: command stream, register port and a shadow point store.
module tb_closed_polyline_subdivider_top;
    import cps_pkg::*;

    localparam int         CAP          = 1024;
    localparam int         MAX_PRINTS   = 40;
    localparam int         PHASES       = 8;
    localparam int         PHASE_ITEMS  = 70;
    localparam int         CLEAR_ABOVE  = 48;
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    typedef struct packed {
        logic signed [CRDW-1:0] x;
        logic signed [CRDW-1:0] y;
        logic [PCW-1:0]         cnt;
        logic [1:0]             st;
    } t_poly_reply;

    typedef struct {
        logic [2:0]             cmd;
        logic [IDXW-1:0]        idx;
        logic signed [CRDW-1:0] x;
        logic signed [CRDW-1:0] y;
        bit                     typed;
        t_poly_reply            reply;
    } t_cmd_row;

    logic                   i_clk;
    logic                   i_rst_n   = 1'b0;
    logic                   start     = 1'b0;
    logic                   busy;
    logic [2:0]             i_command = CMD_CLEAR;
    logic [IDXW-1:0]        i_index   = '0;
    logic signed [CRDW-1:0] i_px      = '0;
    logic signed [CRDW-1:0] i_py      = '0;
    logic                   o_valid;
    logic signed [CRDW-1:0] o_out_x;
    logic signed [CRDW-1:0] o_out_y;
    logic [PCW-1:0]         o_point_count;
    logic [1:0]             o_status;
    logic                   psel      = 1'b0;
    logic                   penable   = 1'b0;
    logic                   pwrite    = 1'b0;
    logic [APB_AW-1:0]      paddr     = '0;
    logic [APB_DW-1:0]      pwdata    = '0;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    // shadow of the point store and the registers
    logic signed [CRDW-1:0] shadow_x [CAP];
    logic signed [CRDW-1:0] shadow_y [CAP];
    int unsigned            shadow_cnt     = 0;
    logic [EDGEW-1:0]       shadow_edge_sq = EDGE_RST;
    logic [PCW-1:0]         shadow_max_pts = PTS_RST;

    t_poly_reply            awaited_replies [$];
    t_cmd_row               directed_rows [$];
    int                     mismatches = 0;
    bit                     no_idle    = 1'b0;

    closed_polyline_subdivider_top #(
        .CAPACITY(CAP)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_command    (i_command),
        .i_index      (i_index),
        .i_px         (i_px),
        .i_py         (i_py),
        .o_valid      (o_valid),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_point_count(o_point_count),
        .o_status     (o_status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        // far above the slowest run, which is dominated by filling the store
        #100_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (mismatches < MAX_PRINTS) begin
            $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        end
        mismatches++;
    endtask

    function automatic void place_point(int unsigned pos, logic signed [CRDW-1:0] x,
                                        logic signed [CRDW-1:0] y);
        int unsigned k;
        for (k = shadow_cnt; k > pos; k--) begin
            shadow_x[k] = shadow_x[k-1];
            shadow_y[k] = shadow_y[k-1];
        end
        shadow_x[pos] = x;
        shadow_y[pos] = y;
        shadow_cnt++;
    endfunction

    function automatic void grow_polyline();
        int unsigned          i;
        int unsigned          j;
        int unsigned          lim;
        longint               dx;
        longint               dy;
        logic signed [CRDW:0] sum_x;
        logic signed [CRDW:0] sum_y;
        lim = (shadow_max_pts < CAP) ? shadow_max_pts : CAP;
        i = 0;
        // the count grows inside the walk, so the new point's edge comes next
        while (i < shadow_cnt) begin
            j  = (i + 1 < shadow_cnt) ? i + 1 : 0;
            dx = longint'(shadow_x[j]) - longint'(shadow_x[i]);
            dy = longint'(shadow_y[j]) - longint'(shadow_y[i]);
            if (dx * dx + dy * dy > longint'(shadow_edge_sq) && shadow_cnt < lim) begin
                // floor of the half sum: drop the low bit of the 17-bit sum
                sum_x = {shadow_x[i][CRDW-1], shadow_x[i]} + {shadow_x[j][CRDW-1], shadow_x[j]};
                sum_y = {shadow_y[i][CRDW-1], shadow_y[i]} + {shadow_y[j][CRDW-1], shadow_y[j]};
                place_point(i + 1, sum_x[CRDW:1], sum_y[CRDW:1]);
            end
            i++;
        end
    endfunction

    function automatic t_poly_reply apply_polyline_cmd(logic [2:0] cmd, logic [IDXW-1:0] idx,
                                                       logic signed [CRDW-1:0] x,
                                                       logic signed [CRDW-1:0] y);
        t_poly_reply r;
        r = '0;
        r.st = ST_OK;
        case (cmd)
            CMD_APPEND: begin
                if (shadow_cnt >= CAP) r.st = ST_FULL;
                else place_point(shadow_cnt, x, y);
            end
            CMD_INSERT: begin
                if (idx > shadow_cnt) r.st = ST_RANGE;
                else if (shadow_cnt >= CAP) r.st = ST_FULL;
                else place_point(idx, x, y);
            end
            CMD_GROW: grow_polyline();
            CMD_READ: begin
                if (idx >= shadow_cnt) begin
                    r.st = ST_RANGE;
                end else begin
                    r.x = shadow_x[idx];
                    r.y = shadow_y[idx];
                end
            end
            CMD_CLEAR: shadow_cnt = 0;
            default: ;
        endcase
        r.cnt = shadow_cnt[PCW-1:0];
        return r;
    endfunction

    function automatic void add_row(logic [2:0] cmd, int idx, int x, int y, bit typed,
                                    int wx, int wy, int wc, logic [1:0] wst);
        t_cmd_row row;
        row.cmd       = cmd;
        row.idx       = IDXW'(idx);
        row.x         = CRDW'(x);
        row.y         = CRDW'(y);
        row.typed     = typed;
        row.reply.x   = CRDW'(wx);
        row.reply.y   = CRDW'(wy);
        row.reply.cnt = PCW'(wc);
        row.reply.st  = wst;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic int idle_cycles();
        int unsigned r;
        if (no_idle) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 4);
    endfunction

    function automatic logic signed [CRDW-1:0] pick_coord();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8) return r[0] ? 16'sh7FFF : 16'sh8000;
        if (r < 50) return CRDW'($urandom);
        return CRDW'($urandom_range(1023)) - 16'sd512;
    endfunction

    task automatic issue_cmd(logic [2:0] cmd, logic [IDXW-1:0] idx, logic signed [CRDW-1:0] x,
                             logic signed [CRDW-1:0] y, bit typed, t_poly_reply reply);
        t_poly_reply predicted;
        int          gap;
        start     <= 1'b1;
        i_command <= cmd;
        i_index   <= idx;
        i_px      <= x;
        i_py      <= y;
        do @(posedge i_clk); while (busy);
        predicted = apply_polyline_cmd(cmd, idx, x, y);
        awaited_replies.insert(awaited_replies.size(), typed ? reply : predicted);
        gap = idle_cycles();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_replies();
        start <= 1'b0;
        @(posedge i_clk);
        while (awaited_replies.size() != 0 || busy) @(posedge i_clk);
    endtask

    // write one register, then read it back
    task automatic program_reg(logic sel, logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] stored;
        if (sel == REG_EDGE) begin
            shadow_edge_sq = value[EDGEW-1:0];
            stored         = APB_DW'(shadow_edge_sq);
        end else begin
            shadow_max_pts = value[PCW-1:0];
            stored         = APB_DW'(shadow_max_pts);
        end
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== stored) flag_mismatch("register read-back", prdata, stored);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : reply_check
        t_poly_reply want;
        if (i_rst_n && o_valid) begin
            if (awaited_replies.size() == 0) begin
                flag_mismatch("reply with nothing pending", o_point_count, '0);
            end else begin
                want = awaited_replies.pop_front();
                if (o_out_x !== want.x) flag_mismatch("out_x", o_out_x, want.x);
                if (o_out_y !== want.y) flag_mismatch("out_y", o_out_y, want.y);
                if (o_point_count !== want.cnt) flag_mismatch("point_count", o_point_count, want.cnt);
                if (o_status !== want.st) flag_mismatch("status", o_status, want.st);
            end
        end
    end

    initial begin
        int unsigned      ph;
        int unsigned      n;
        int unsigned      r;
        logic [2:0]       cmd;
        logic [IDXW-1:0]  idx;
        logic [EDGEW-1:0] edge_cfg;
        logic [PCW-1:0]   pts_cfg;

        // empty store, single point, range errors, spare code, extreme midpoint
        add_row(CMD_READ,     0,      0,      0,      1, 0, 0, 0, ST_RANGE);
        add_row(CMD_GROW,     0,      0,      0,      1, 0, 0, 0, ST_OK);
        add_row(CMD_APPEND,   0,      -32768, 32767,  1, 0, 0, 1, ST_OK);
        add_row(CMD_GROW,     0,      0,      0,      1, 0, 0, 1, ST_OK);
        add_row(CMD_INSERT,   2,      5,      5,      1, 0, 0, 1, ST_RANGE);
        add_row(CMD_INSERT,   1,      32767,  -32768, 1, 0, 0, 2, ST_OK);
        add_row(CMD_READ,     1023,   0,      0,      1, 0, 0, 2, ST_RANGE);
        add_row(CMD_SPARE_HI, 0,      0,      0,      1, 0, 0, 2, ST_OK);
        add_row(CMD_GROW,     0,      0,      0,      0, 0, 0, 0, ST_OK);
        add_row(CMD_READ,     1,      0,      0,      0, 0, 0, 0, ST_OK);
        add_row(CMD_CLEAR,    0,      0,      0,      1, 0, 0, 0, ST_OK);
        // a large square, split by grow passes until the store is full
        add_row(CMD_APPEND,   0,      -16000, -16000, 1, 0, 0, 1, ST_OK);
        add_row(CMD_APPEND,   0,      16000,  -16000, 1, 0, 0, 2, ST_OK);
        add_row(CMD_APPEND,   0,      16000,  16000,  1, 0, 0, 3, ST_OK);
        add_row(CMD_APPEND,   0,      -16000, 16000,  1, 0, 0, 4, ST_OK);
        repeat (6) add_row(CMD_GROW, 0, 0, 0, 0, 0, 0, 0, ST_OK);
        add_row(CMD_APPEND,   0,      0,      0,      1, 0, 0, CAP, ST_FULL);
        add_row(CMD_INSERT,   0,      0,      0,      1, 0, 0, CAP, ST_FULL);
        add_row(CMD_READ,     1023,   0,      0,      0, 0, 0, 0, ST_OK);
        add_row(CMD_CLEAR,    0,      0,      0,      1, 0, 0, 0, ST_OK);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            issue_cmd(directed_rows[k].cmd, directed_rows[k].idx, directed_rows[k].x,
                      directed_rows[k].y, directed_rows[k].typed, directed_rows[k].reply);
        end

        for (ph = 0; ph < PHASES; ph++) begin
            drain_replies();
            case (ph)
                0: begin
                    edge_cfg = '0;
                    pts_cfg  = 11'd2;
                end
                1: begin
                    edge_cfg = 35'h4_0000_0000;
                    pts_cfg  = 11'd1024;
                end
                2: begin
                    edge_cfg = '0;
                    pts_cfg  = PCW'($urandom_range(64, 3));
                end
                3: begin
                    // only very long edges split, so a high limit stays cheap
                    edge_cfg = {1'b0, 2'($urandom), 32'($urandom)} | 35'h1000_0000;
                    pts_cfg  = PCW'($urandom_range(1023, 65));
                end
                default: begin
                    r = $urandom_range(2);
                    if (r == 0) edge_cfg = EDGEW'($urandom_range(32'hFF_FFFF));
                    else if (r == 1) edge_cfg = EDGEW'($urandom_range(4095));
                    else edge_cfg = EDGE_RST;
                    pts_cfg = PCW'($urandom_range(64, 2));
                end
            endcase
            program_reg(REG_EDGE, APB_DW'(edge_cfg));
            program_reg(REG_PTS, APB_DW'(pts_cfg));
            no_idle = (ph == 4) || ($urandom_range(3) == 0);

            for (n = 0; n < PHASE_ITEMS; n++) begin
                r   = $urandom_range(99);
                idx = IDXW'($urandom_range(1023));
                if (shadow_cnt > CLEAR_ABOVE) cmd = CMD_CLEAR;
                else if (r < 30) cmd = CMD_APPEND;
                else if (r < 52) cmd = CMD_INSERT;
                else if (r < 74) cmd = CMD_READ;
                else if (r < 86) cmd = CMD_GROW;
                else if (r < 92) cmd = CMD_CLEAR;
                else cmd = 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
                // keep most positions in range; the rest hit the range check
                if ($urandom_range(99) < 85) begin
                    if (cmd == CMD_INSERT) begin
                        idx = IDXW'($urandom_range(shadow_cnt));
                    end else if (cmd == CMD_READ && shadow_cnt > 0) begin
                        idx = IDXW'($urandom_range(shadow_cnt - 1));
                    end
                end
                if ($urandom_range(99) < 3) drain_replies();
                issue_cmd(cmd, idx, pick_coord(), pick_coord(), 1'b0, '0);
            end
        end

        drain_replies();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cps_pkg.sv
rtl/cps_regs.sv
rtl/closed_polyline_subdivider_top.sv
tb/tb_closed_polyline_subdivider_top.sv
